[rtl/usf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usf_pkg
// Shared constants, types and controller/datapath signal groups of the
// universal sink finder.
// ----------------------------------------------------------------------------
package usf_pkg;

	localparam int MAX_NODES = 32;
	localparam int ROW_W     = 32;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES) + 1;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register index, taken from the word address bits of paddr.
	localparam logic REG_NODE_COUNT = 1'b0;

	localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ELIM,
		ST_VERIFY
	} usf_state_t;

	typedef struct packed {
		logic row_wr;
		logic elim_issue;
		logic ver_init;
		logic ver_issue;
		logic publish;
	} usf_cmd_t;

	typedef struct packed {
		logic final_row;
		logic out_busy;
		logic elim_end;
		logic ver_end;
		logic s1_busy;
	} usf_status_t;

endpackage

[rtl/usf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usf_if
// Valid/ready channels of the universal sink finder: matrix rows in,
// results out.
// ----------------------------------------------------------------------------
interface usf_row_if import usf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_bits;

	modport source (output valid, output row_bits, input ready);
	modport sink (input valid, input row_bits, output ready);
endinterface

interface usf_result_if import usf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [IDX_W-1:0] celebrity_index;

	modport source (output valid, output found, output celebrity_index, input ready);
	modport sink (input valid, input found, input celebrity_index, output ready);
endinterface

[rtl/universal_sink_finder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// universal_sink_finder_top
// Finds the universal sink (celebrity) of a knows-relation matrix loaded
// one row per word, with an APB-style port for the person count.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle and written to the row memory. The word
// carrying row node_count-1 starts the search. The elimination sweep reads
// one row per cycle (node_count-1 reads; the last read drains before the
// hand-over to the column check). The column check then reads all
// node_count rows in the same way (node_count reads; the last read drains
// before the result is published). The input stalls for the whole search.
// Ordinary rows of the next matrix flow as soon as the search ends; only
// its final row waits while the previous result has not yet been taken.
// The person count register sits at byte address 0; only the low 6 bits
// of a write are kept, and of those 0 acts as 1 and values above 32 act
// as 32.
module universal_sink_finder_top import usf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	usf_row_if.sink               row_in,
	usf_result_if.source          result_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [CNT_W-1:0] node_count_q;
	logic             cfg_wr;
	usf_cmd_t         cmd;
	usf_status_t      status;
	usf_state_t       state;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_NODE_COUNT) begin
			node_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[CFG_ADDR_W-1] == REG_NODE_COUNT)
		? CFG_DATA_W'(node_count_q) : '0;

	usf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (row_in.valid),
		.in_ready (row_in.ready),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	usf_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.node_count      (node_count_q),
		.row_bits        (row_in.row_bits),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (result_out.valid),
		.out_ready       (result_out.ready),
		.found           (result_out.found),
		.celebrity_index (result_out.celebrity_index)
	);

	a_index_zero_when_none: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.found) |-> (result_out.celebrity_index == '0))
		else $error("celebrity index not zero on a result without a celebrity");

	a_stall_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(row_in.valid && row_in.ready && status.final_row) |=> !row_in.ready)
		else $error("input taken while the search is running");

	a_result_from_verify: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_out.valid) |-> $past(state == ST_VERIFY))
		else $error("result raised outside the end of the column check");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_ELIM || state == ST_VERIFY) |-> !cmd.row_wr)
		else $error("row written during the search");

endmodule

[rtl/usf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usf_ctrl
// Sequencer: row loading, the elimination sweep, the column check and the
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module usf_ctrl import usf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  usf_status_t status,
	output usf_cmd_t    cmd,
	output usf_state_t  state
);

	usf_state_t state_q;
	usf_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				// The final row waits while the previous result is still unclaimed.
				in_ready   = !(status.final_row && status.out_busy);
				cmd.row_wr = in_valid && in_ready;
				if (cmd.row_wr && status.final_row) begin
					state_nxt = ST_ELIM;
				end
			end
			ST_ELIM: begin
				cmd.elim_issue = !status.elim_end;
				if (status.elim_end && !status.s1_busy) begin
					cmd.ver_init = 1'b1;
					state_nxt    = ST_VERIFY;
				end
			end
			ST_VERIFY: begin
				cmd.ver_issue = !status.ver_end;
				if (status.ver_end && !status.s1_busy) begin
					cmd.publish = 1'b1;
					state_nxt   = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	assign state = state_q;

endmodule

[rtl/usf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usf_datapath
// Row memory, load counter, candidate and column count, and the result
// register.
// ----------------------------------------------------------------------------
module usf_datapath import usf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] node_count,
	input  logic [ROW_W-1:0] row_bits,
	input  usf_cmd_t         cmd,
	output usf_status_t      status,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             found,
	output logic [IDX_W-1:0] celebrity_index
);

	logic [ROW_W-1:0] mem [MAX_NODES];
	logic [ROW_W-1:0] rd_data_s1;
	logic [IDX_W-1:0] tag_s1;
	logic             vld_s1;
	logic             ver_s1;

	logic [CNT_W-1:0] rows_loaded_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] ones_q;
	logic [IDX_W-1:0] cand_q;
	logic [ROW_W-1:0] cand_row_q;
	logic             out_valid_q;
	logic             out_found_q;
	logic [IDX_W-1:0] out_idx_q;

	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] last_idx;
	logic             final_row;
	logic [IDX_W-1:0] wr_idx;
	logic [CNT_W-1:0] ptr_dec;
	logic [IDX_W-1:0] rd_addr;
	logic [ROW_W-1:0] col_mask;
	logic             ok;

	// Clamp the person count to 1 .. MAX_NODES.
	always_comb begin
		if (node_count == '0) begin
			n_eff = CNT_W'(1);
		end else if (node_count > CNT_W'(MAX_NODES)) begin
			n_eff = CNT_W'(MAX_NODES);
		end else begin
			n_eff = node_count;
		end
	end

	assign last_idx  = n_eff - CNT_W'(1);
	assign final_row = (rows_loaded_q >= last_idx);
	assign wr_idx    = final_row ? last_idx[IDX_W-1:0] : rows_loaded_q[IDX_W-1:0];
	assign ptr_dec   = ptr_q - CNT_W'(1);
	assign rd_addr   = cmd.elim_issue ? ptr_dec[IDX_W-1:0] : ptr_q[IDX_W-1:0];

	// A shift by the full row width leaves zero, so a full matrix gets all ones.
	assign col_mask = ~({ROW_W{1'b1}} << n_q);
	assign ok       = ((cand_row_q & col_mask) == '0) && (ones_q == n_q - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.row_wr) begin
			mem[wr_idx] <= row_bits;
		end
		rd_data_s1 <= mem[rd_addr];
		tag_s1     <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_loaded_q <= '0;
			ptr_q         <= '0;
			vld_s1        <= 1'b0;
			ver_s1        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			vld_s1 <= cmd.elim_issue || cmd.ver_issue;
			ver_s1 <= cmd.ver_issue;
			if (cmd.row_wr) begin
				rows_loaded_q <= final_row ? '0 : CNT_W'(wr_idx) + CNT_W'(1);
				if (final_row) begin
					ptr_q <= last_idx;
				end
			end else if (cmd.ver_init) begin
				ptr_q <= '0;
			end else if (cmd.elim_issue) begin
				ptr_q <= ptr_dec;
			end else if (cmd.ver_issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_wr && final_row) begin
			n_q        <= n_eff;
			cand_q     <= last_idx[IDX_W-1:0];
			cand_row_q <= row_bits;
		end else if (vld_s1 && !ver_s1 && cand_row_q[tag_s1]) begin
			// The candidate knows this person, so the candidate cannot be the sink.
			cand_q     <= tag_s1;
			cand_row_q <= rd_data_s1;
		end
		if (cmd.ver_init) begin
			ones_q <= '0;
		end else if (vld_s1 && ver_s1 && rd_data_s1[cand_q]) begin
			ones_q <= ones_q + CNT_W'(1);
		end
		if (cmd.publish) begin
			out_found_q <= ok;
			out_idx_q   <= ok ? cand_q : '0;
		end
	end

	assign status.final_row = final_row;
	assign status.out_busy  = out_valid_q;
	assign status.elim_end  = (ptr_q == '0);
	assign status.ver_end   = (ptr_q == n_q);
	assign status.s1_busy   = vld_s1;

	assign out_valid       = out_valid_q;
	assign found           = out_found_q;
	assign celebrity_index = out_idx_q;

endmodule
